// ----- rtl/core/apvt_pkg.sv -----
package apvt_pkg;

    // fraction bits of the signed fixed-point format
    localparam int FRAC_BITS = 16;

    // coefficient store: three rows of four
    localparam int NROWS  = 3;
    localparam int NCOLS  = 4;
    localparam int NCOEF  = NROWS * NCOLS;
    localparam int IDX_W  = 4;
    localparam int DATA_W = 32;

    // full product, shifted product and sum widths
    localparam int PROD_W = 2 * DATA_W;
    localparam int SHR_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W  = SHR_W + 2;

    // fixed-point one, reset value of the diagonal
    localparam logic signed [DATA_W-1:0] COEF_ONE = DATA_W'(1) <<< FRAC_BITS;

    // request operation codes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_POINT = 2'd1,
        OP_DIR   = 2'd2
    } t_op;

    typedef logic signed [DATA_W-1:0] t_coef;
    typedef t_coef t_row [NCOLS];
    typedef t_coef t_mat [NCOEF];

    // coefficient write port
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } t_coef_wr;

endpackage

// ----- rtl/core/apvt_coef_regs.sv -----
module apvt_coef_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  apvt_pkg::t_coef_wr i_wr,
    output apvt_pkg::t_mat     o_mat
);

    apvt_pkg::t_mat r_coef;

    // coefficient registers, identity rows after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < apvt_pkg::NCOEF; i++) begin
                if (i == 0 || i == apvt_pkg::NCOLS + 1 || i == 2 * apvt_pkg::NCOLS + 2) begin
                    r_coef[i] <= apvt_pkg::COEF_ONE;
                end else begin
                    r_coef[i] <= '0;
                end
            end
        end else if (i_wr.en && (i_wr.idx < apvt_pkg::IDX_W'(apvt_pkg::NCOEF))) begin
            r_coef[i_wr.idx] <= $signed(i_wr.data);
        end
    end

    assign o_mat = r_coef;

endmodule

// ----- rtl/core/apvt_row.sv -----
module apvt_row (
    input  apvt_pkg::t_row                      i_row,
    input  logic signed [apvt_pkg::DATA_W-1:0]  i_x,
    input  logic signed [apvt_pkg::DATA_W-1:0]  i_y,
    input  logic signed [apvt_pkg::DATA_W-1:0]  i_z,
    input  logic                                i_add_trans,
    output logic signed [apvt_pkg::DATA_W-1:0]  o_res,
    output logic                                o_ovf
);

    logic signed [apvt_pkg::PROD_W-1:0] w_prod [3];
    logic signed [apvt_pkg::SUM_W-1:0]  w_term [3];
    logic signed [apvt_pkg::SUM_W-1:0]  w_trans;
    logic signed [apvt_pkg::SUM_W-1:0]  w_sum;
    logic [apvt_pkg::SUM_W-apvt_pkg::DATA_W:0] w_hi;
    logic                               w_pos_ovf;
    logic                               w_neg_ovf;

    // three products, floored by the fraction shift
    assign w_prod[0] = i_row[0] * i_x;
    assign w_prod[1] = i_row[1] * i_y;
    assign w_prod[2] = i_row[2] * i_z;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_term[c] = $signed({{2{w_prod[c][apvt_pkg::PROD_W-1]}},
                                 w_prod[c][apvt_pkg::PROD_W-1:apvt_pkg::FRAC_BITS]});
        end
    end

    // translation column only for points
    assign w_trans = i_add_trans
        ? $signed({{(apvt_pkg::SUM_W-apvt_pkg::DATA_W){i_row[3][apvt_pkg::DATA_W-1]}}, i_row[3]})
        : '0;

    assign w_sum = w_term[0] + w_term[1] + w_term[2] + w_trans;

    // saturate to the output width
    assign w_hi      = w_sum[apvt_pkg::SUM_W-1:apvt_pkg::DATA_W-1];
    assign w_pos_ovf = !w_sum[apvt_pkg::SUM_W-1] && (|w_hi);
    assign w_neg_ovf = w_sum[apvt_pkg::SUM_W-1] && !(&w_hi);

    always_comb begin
        if (w_pos_ovf) begin
            o_res = {1'b0, {(apvt_pkg::DATA_W-1){1'b1}}};
        end else if (w_neg_ovf) begin
            o_res = {1'b1, {(apvt_pkg::DATA_W-1){1'b0}}};
        end else begin
            o_res = w_sum[apvt_pkg::DATA_W-1:0];
        end
    end

    assign o_ovf = w_pos_ovf || w_neg_ovf;

endmodule

// ----- rtl/core/affine_point_vector_transform.sv -----
// Vertex transform unit for signed Q16.16 data. Load requests write one of
// twelve coefficients (rows 0 to 2 of an affine 4x4 matrix, index row*4+col)
// at the edge they are accepted and give no result; the next request already
// sees the new value. Point requests return the rows times (x,y,z,1), direction
// requests the upper 3x3 times (x,y,z); products are floored by the fraction
// shift and each sum saturates to 32 bits, raising o_overflow. One request is
// taken every cycle while the output is not stalled; a transform request passes
// from the input register through the nine parallel 32x32 multipliers with
// their saturating adders to the result register, which offers the result at
// the outputs. Operation code three and load indexes above eleven are
// dropped. After reset the matrix is the identity.
module affine_point_vector_transform (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_op,
    input  logic [3:0]                          i_coef_index,
    input  logic signed [31:0]                  i_coef_value,
    input  logic signed [31:0]                  i_in_x,
    input  logic signed [31:0]                  i_in_y,
    input  logic signed [31:0]                  i_in_z,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [31:0]                  o_out_x,
    output logic signed [31:0]                  o_out_y,
    output logic signed [31:0]                  o_out_z,
    output logic                                o_overflow
);

    logic                                r_in_valid;
    logic                                r_add_trans;
    logic signed [apvt_pkg::DATA_W-1:0]  r_x;
    logic signed [apvt_pkg::DATA_W-1:0]  r_y;
    logic signed [apvt_pkg::DATA_W-1:0]  r_z;
    logic                                r_out_valid;
    logic signed [apvt_pkg::DATA_W-1:0]  r_out [3];
    logic                                r_ovf;

    logic                                w_accept;
    logic                                w_adv;
    logic                                w_is_xf;
    logic                                w_is_point;
    apvt_pkg::t_coef_wr                  w_wr;
    apvt_pkg::t_mat                      w_mat;
    apvt_pkg::t_row                      w_rows [3];
    logic signed [apvt_pkg::DATA_W-1:0]  n_out [3];
    logic [2:0]                          n_ovf;

    // handshake: result register frees, input register follows
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    // decode the request
    always_comb begin
        w_is_xf    = 1'b0;
        w_is_point = 1'b0;
        w_wr.en    = 1'b0;
        w_wr.idx   = i_coef_index;
        w_wr.data  = i_coef_value;
        case (apvt_pkg::t_op'(i_op))
            apvt_pkg::OP_LOAD: begin
                w_wr.en = w_accept;
            end
            apvt_pkg::OP_POINT: begin
                w_is_xf    = 1'b1;
                w_is_point = 1'b1;
            end
            apvt_pkg::OP_DIR: begin
                w_is_xf = 1'b1;
            end
            default: begin
                w_is_xf = 1'b0;
            end
        endcase
    end

    apvt_coef_regs u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .o_mat   (w_mat)
    );

    // input register, transform requests only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv || !r_in_valid) begin
            r_in_valid <= w_accept && w_is_xf;
        end
        if (w_accept && w_is_xf) begin
            r_add_trans <= w_is_point;
            r_x         <= i_in_x;
            r_y         <= i_in_y;
            r_z         <= i_in_z;
        end
    end

    // one row datapath per output component
    for (genvar g = 0; g < apvt_pkg::NROWS; g++) begin : g_row
        for (genvar c = 0; c < apvt_pkg::NCOLS; c++) begin : g_col
            assign w_rows[g][c] = w_mat[g * apvt_pkg::NCOLS + c];
        end

        apvt_row u_row (
            .i_row       (w_rows[g]),
            .i_x         (r_x),
            .i_y         (r_y),
            .i_z         (r_z),
            .i_add_trans (r_add_trans),
            .o_res       (n_out[g]),
            .o_ovf       (n_ovf[g])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
        if (w_adv && r_in_valid) begin
            r_out[0] <= n_out[0];
            r_out[1] <= n_out[1];
            r_out[2] <= n_out[2];
            r_ovf    <= |n_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_overflow  = r_ovf;

    // stall only while the input register is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stall without a held request");

    // a held transform request is never dropped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid)
        else $error("held transform request lost");

    // an advancing transform request lands in the result register
    a_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_adv |=> r_out_valid)
        else $error("transform result lost");

endmodule
